// ===== design/panel_frame_encoder_assert.svh =====
// assertion macros shared by the encoder modules
`ifndef PANEL_FRAME_ENCODER_ASSERT_SVH
`define PANEL_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("panel_frame_encoder assertion failed");

// next-cycle implication, checked out of reset
`define PFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("panel_frame_encoder assertion failed");

`endif

// ===== design/pfe_pkg.sv =====
`timescale 1ns / 1ps

package pfe_pkg;

    // framing constants
    localparam logic [15:0] SUM_INIT   = 16'h147A;
    localparam logic [7:0]  MARK_BYTE  = 8'hFE;
    localparam logic [7:0]  STUFF_BYTE = 8'hF0;
    localparam logic [7:0]  CLOSE_BYTE = 8'h0D;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one classified command byte, ready for the back end
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        prefix;
        logic [15:0] sum;
    } job_t;

    // rotate left, invert, add own high byte and data byte, mod 2^16
    function automatic logic [15:0] sum_update(input logic [15:0] s, input logic [7:0] d);
        logic [15:0] v;
        v = ~{s[14:0], s[15]};
        return v + {8'h00, v[15:8]} + {8'h00, d};
    endfunction

endpackage

// ===== design/panel_frame_encoder.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// command   in         push / full            data_byte[7:0], last_byte
// line      out        empty / pop            out_byte[7:0], run_end, frame_end
//
// the front takes one command byte per cycle while the four-entry job queue has room
// the back emits one line byte per cycle while the output register is free or popped:
// FE FE if a frame opens, the data byte, on the last checksum high, low, FE, 0D; F0 after
// each data or checksum byte equal to FE; a result waits in the output register while the back
// keeps its job and the front fills the queue; full rises only when four jobs are waiting
// reset (rst_n low, asynchronous) empties the queue and output, checksum back to 147A

module panel_frame_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        run_end,
    output logic        frame_end
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    pfe_pkg::job_t  q_job;
    pfe_pkg::job_t  q_head;

    // checksum and classification
    pfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_push    (q_push),
        .q_job     (q_job),
        .q_full    (q_full)
    );

    // job queue
    pfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_job   (q_job),
        .q_full   (q_full),
        .rd_en    (q_pop),
        .rd_job   (q_head),
        .rd_valid (q_valid)
    );

    // byte sequencer and output register
    pfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (q_valid),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .run_end    (run_end),
        .frame_end  (frame_end)
    );

endmodule

// ===== design/pfe_front.sv =====
`timescale 1ns / 1ps

module pfe_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [7:0]     data_byte,
    input  logic           last_byte,
    output logic           q_push,
    output pfe_pkg::job_t  q_job,
    input  logic           q_full
);

    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic        inside_reg;
    logic        inside_next;
    logic [15:0] sum_upd;

    // input transaction accepted whenever the queue has room
    assign full   = q_full;
    assign q_push = push && !q_full;

    // checksum update and job classification
    always_comb
    begin
        sum_upd      = pfe_pkg::sum_update(sum_reg, data_byte);
        q_job.data   = data_byte;
        q_job.last   = last_byte;
        q_job.prefix = !inside_reg;
        q_job.sum    = sum_upd;
        sum_next     = sum_reg;
        inside_next  = inside_reg;
        if (q_push)
        begin
            if (last_byte)
            begin
                sum_next    = pfe_pkg::SUM_INIT;
                inside_next = 1'b0;
            end
            else
            begin
                sum_next    = sum_upd;
                inside_next = 1'b1;
            end
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= pfe_pkg::SUM_INIT;
            inside_reg <= 1'b0;
        end
        else
        begin
            sum_reg    <= sum_next;
            inside_reg <= inside_next;
        end
    end

endmodule

// ===== design/pfe_queue.sv =====
`timescale 1ns / 1ps

`include "panel_frame_encoder_assert.svh"

module pfe_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  pfe_pkg::job_t  wr_job,
    output logic           q_full,
    input  logic           rd_en,
    output pfe_pkg::job_t  rd_job,
    output logic           rd_valid
);

    localparam logic [pfe_pkg::QUEUE_AW-1:0] LAST_PTR =
        pfe_pkg::QUEUE_AW'(pfe_pkg::QUEUE_DEPTH - 1);
    localparam logic [pfe_pkg::QUEUE_AW:0] DEPTH_CNT =
        (pfe_pkg::QUEUE_AW + 1)'(pfe_pkg::QUEUE_DEPTH);

    pfe_pkg::job_t                 slot_reg [pfe_pkg::QUEUE_DEPTH];
    logic [pfe_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [pfe_pkg::QUEUE_AW-1:0]  wr_ptr_next;
    logic [pfe_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [pfe_pkg::QUEUE_AW-1:0]  rd_ptr_next;
    logic [pfe_pkg::QUEUE_AW:0]    count_reg;
    logic [pfe_pkg::QUEUE_AW:0]    count_next;

    // status and head entry
    assign q_full   = (count_reg == DEPTH_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_job   = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    `PFE_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_CNT)
    `PFE_ASSERT_NOW(a_no_underflow, clk, rst_n, rd_en, rd_valid)
    `PFE_ASSERT_NOW(a_no_overflow, clk, rst_n, wr_en, !q_full)
    `PFE_ASSERT_NEXT(a_cnt_up, clk, rst_n, wr_en && !rd_en, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== design/pfe_back.sv =====
`timescale 1ns / 1ps

`include "panel_frame_encoder_assert.svh"

module pfe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  pfe_pkg::job_t  head,
    input  logic           head_valid,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     out_byte,
    output logic           run_end,
    output logic           frame_end
);

    typedef enum logic [3:0] {
        S_START,
        S_PRE1,
        S_PRE2,
        S_DATA,
        S_DSTUFF,
        S_SUMH,
        S_HSTUFF,
        S_SUML,
        S_LSTUFF,
        S_SUF1,
        S_SUF2
    } step_t;

    step_t       step_reg;
    step_t       step_next;
    step_t       cur_step;
    step_t       nxt_step;
    logic        fin;
    logic        adv;
    logic [7:0]  byte_sel;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        run_end_reg;
    logic        frame_end_reg;

    // first step of a job depends on whether a frame must open
    assign cur_step = (step_reg == S_START) ? (head.prefix ? S_PRE1 : S_DATA) : step_reg;

    // byte select and successor step
    always_comb
    begin
        byte_sel = pfe_pkg::MARK_BYTE;
        nxt_step = S_START;
        fin      = 1'b0;
        unique case (cur_step)
            S_PRE1:
            begin
                nxt_step = S_PRE2;
            end
            S_PRE2:
            begin
                nxt_step = S_DATA;
            end
            S_DATA:
            begin
                byte_sel = head.data;
                if (head.data == pfe_pkg::MARK_BYTE)
                    nxt_step = S_DSTUFF;
                else if (head.last)
                    nxt_step = S_SUMH;
                else
                    fin = 1'b1;
            end
            S_DSTUFF:
            begin
                byte_sel = pfe_pkg::STUFF_BYTE;
                if (head.last)
                    nxt_step = S_SUMH;
                else
                    fin = 1'b1;
            end
            S_SUMH:
            begin
                byte_sel = head.sum[15:8];
                nxt_step = (head.sum[15:8] == pfe_pkg::MARK_BYTE) ? S_HSTUFF : S_SUML;
            end
            S_HSTUFF:
            begin
                byte_sel = pfe_pkg::STUFF_BYTE;
                nxt_step = S_SUML;
            end
            S_SUML:
            begin
                byte_sel = head.sum[7:0];
                nxt_step = (head.sum[7:0] == pfe_pkg::MARK_BYTE) ? S_LSTUFF : S_SUF1;
            end
            S_LSTUFF:
            begin
                byte_sel = pfe_pkg::STUFF_BYTE;
                nxt_step = S_SUF1;
            end
            S_SUF1:
            begin
                nxt_step = S_SUF2;
            end
            S_SUF2:
            begin
                byte_sel = pfe_pkg::CLOSE_BYTE;
                fin      = 1'b1;
            end
            default:
            begin
                nxt_step = S_START;
            end
        endcase
    end

    // one byte per cycle into the output register when it is free or being taken
    assign adv            = head_valid && (!out_valid_reg || pop);
    assign q_pop          = adv && fin;
    assign step_next      = !adv ? step_reg : (fin ? S_START : nxt_step);
    assign out_valid_next = adv ? 1'b1 : (pop ? 1'b0 : out_valid_reg);

    // sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_START;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            run_end_reg   <= 1'b0;
            frame_end_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                out_byte_reg  <= byte_sel;
                run_end_reg   <= fin;
                frame_end_reg <= (cur_step == S_SUF2);
            end
        end
    end

    assign empty     = !out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_end   = run_end_reg;
    assign frame_end = frame_end_reg;

    `PFE_ASSERT_NOW(a_mid_job_head, clk, rst_n, step_reg != S_START, head_valid)
    `PFE_ASSERT_NEXT(a_suffix_order, clk, rst_n, adv && cur_step == S_SUF1, step_reg == S_SUF2)
    `PFE_ASSERT_NOW(a_close_byte, clk, rst_n, out_valid_reg && frame_end_reg, run_end_reg && out_byte_reg == pfe_pkg::CLOSE_BYTE)

endmodule
